// ===== hdl/wtss_pkg.sv =====
// Shared constants, register indexes and the crossing test for the weekly time switch.
// Used by weekly_time_switch_scheduler; depends on nothing else.
package wtss_pkg;

  localparam int CHANNELS  = 4;
  localparam int SEC_W     = 17;
  localparam int WDAY_W    = 3;
  localparam int DAYS_PER_CH = 7;
  localparam int TIMES_W   = 2 * SEC_W;
  localparam int DMASK_W   = CHANNELS * DAYS_PER_CH;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = TIMES_W;

  localparam logic [SEC_W-1:0] SEC_PER_DAY    = SEC_W'(86400);
  localparam logic [SEC_W-1:0] CATCHUP_WINDOW = SEC_W'(15);

  localparam logic [CFG_IDX_W-1:0] REG_CHAN0_TIMES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN1_TIMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN2_TIMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN3_TIMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_MASKS   = 3'd4;

  typedef logic [SEC_W-1:0]   sec_t;
  typedef logic [TIMES_W-1:0] chan_times_t;
  typedef logic [CHANNELS-1:0] chan_mask_t;

  // A setting fires when it lies in (last, now], wrapping past midnight.
  function automatic logic crossed(sec_t s, sec_t last, sec_t now);
    logic hit;
    if (s >= SEC_PER_DAY) begin
      hit = 1'b0;
    end else if (now > last) begin
      hit = (s > last) && (s <= now);
    end else begin
      hit = (s > last) || (s <= now);
    end
    return hit;
  endfunction

endpackage

// ===== hdl/weekly_time_switch_scheduler.sv =====
// Weekly programmable time switch: top level with input stage, compare logic and result register.
// Depends on wtss_pkg for constants, register indexes and the crossing test.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one clock sample per word: the second of
//   the day and the weekday. The output channel (out_valid/out_ready) carries a word with
//   the on and off masks, one bit per channel, and only when at least one bit is set.
//   The configuration port writes one register per cycle where cfg_write_en is high:
//   four channel time registers (on second low, off second high) and the day masks.
//   An accepted sample sits in the input register until it can leave; its comparison against
//   the tracked second is done there, and a result is loaded into the output register
//   as the sample leaves, and shown in the next cycle.
//   One sample is accepted every cycle unless a sample waits in the input register; the tracked
//   second has a register of its own and may be updated as a sample leaves the input register.
//   The first in-range sample after reset only loads the tracked second. Reset clears the
//   settings, the tracked second and both valid flags.
//   When the receiver stalls with a result pending, a sample that yields no result still
//   passes; a sample that yields a result waits in the input register, and in_ready drops.
module weekly_time_switch_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wtss_pkg::SEC_W-1:0]     in_now_second,
  input  logic [wtss_pkg::WDAY_W-1:0]    in_weekday,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wtss_pkg::CHANNELS-1:0]  out_on_mask,
  output logic [wtss_pkg::CHANNELS-1:0]  out_off_mask,
  input  logic                           cfg_write_en,
  input  logic [wtss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wtss_pkg::*;

  chan_times_t            chan_times_r [CHANNELS];
  logic [DMASK_W-1:0]     day_masks_r;

  logic                   s1_valid_r;
  sec_t                   s1_now_r;
  logic [WDAY_W-1:0]      s1_wd_r;

  sec_t                   last_second_r, last_second_nxt;
  logic                   primed_r, primed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  chan_mask_t             out_on_r, out_off_r;

  logic                   in_range;
  logic [SEC_W:0]         diff_wide;
  sec_t                   diff;
  logic                   step_fwd, step_resync;
  logic [WDAY_W-1:0]      wd_idx;
  chan_mask_t             on_hit, off_hit;
  logic                   produce;
  logic                   s1_adv;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < CHANNELS; n++) begin
        chan_times_r[n] <= '0;
      end
      day_masks_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_CHAN0_TIMES: chan_times_r[0] <= cfg_data;
        REG_CHAN1_TIMES: chan_times_r[1] <= cfg_data;
        REG_CHAN2_TIMES: chan_times_r[2] <= cfg_data;
        REG_CHAN3_TIMES: chan_times_r[3] <= cfg_data;
        REG_DAY_MASKS:   day_masks_r     <= cfg_data[DMASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare logic on the registered sample.
  always_comb begin
    in_range  = s1_now_r < SEC_PER_DAY;
    if (s1_now_r >= last_second_r) begin
      diff_wide = {1'b0, s1_now_r} - {1'b0, last_second_r};
    end else begin
      diff_wide = {1'b0, s1_now_r} + {1'b0, SEC_PER_DAY} - {1'b0, last_second_r};
    end
    diff        = diff_wide[SEC_W-1:0];
    step_fwd    = (diff != '0) && (diff < CATCHUP_WINDOW);
    // Small backward steps land above a day minus the window and are ignored.
    step_resync = (diff >= CATCHUP_WINDOW) && (diff <= SEC_PER_DAY - CATCHUP_WINDOW);
    wd_idx      = s1_wd_r - WDAY_W'(1);

    for (int n = 0; n < CHANNELS; n++) begin
      logic [DAYS_PER_CH-1:0] days;
      logic                   day_ok;
      days       = day_masks_r[DAYS_PER_CH*n +: DAYS_PER_CH];
      day_ok     = (s1_wd_r != '0) && days[wd_idx];
      on_hit[n]  = day_ok && crossed(chan_times_r[n][SEC_W-1:0], last_second_r, s1_now_r);
      off_hit[n] = day_ok && crossed(chan_times_r[n][TIMES_W-1:SEC_W], last_second_r,
                                     s1_now_r);
    end

    produce = in_range && primed_r && step_fwd && ((on_hit | off_hit) != '0);
    s1_adv  = s1_valid_r && (!produce || !out_valid_r || out_ready);

    last_second_nxt = last_second_r;
    primed_nxt      = primed_r;
    if (s1_adv && in_range) begin
      if (!primed_r) begin
        primed_nxt      = 1'b1;
        last_second_nxt = s1_now_r;
      end else if (step_fwd || step_resync) begin
        last_second_nxt = s1_now_r;
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_adv && produce) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      last_second_r <= '0;
      primed_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      last_second_r <= last_second_nxt;
      primed_r      <= primed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_r <= in_now_second;
      s1_wd_r  <= in_weekday;
    end
    if (s1_adv && produce) begin
      out_on_r  <= on_hit;
      out_off_r <= off_hit;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_on_mask  = out_on_r;
  assign out_off_mask = out_off_r;

  // A shown result always carries at least one set bit.
  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_on_r | out_off_r) != '0))
    else $error("result word shown with both masks empty");

  // Once primed, the block stays primed until reset.
  a_primed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped without reset");

  // The tracked second never leaves the day.
  a_last_in_day: assert property (@(posedge clk) disable iff (!rst_n)
    last_second_r < SEC_PER_DAY)
    else $error("tracked second out of range");

  // A result that leaves the input stage is shown in the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && produce) |=> out_valid_r)
    else $error("result lost between stages");

  // A sample held in the input stage blocks new samples.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_now_r)))
    else $error("held sample overwritten");

endmodule
